// File: hdl/vlcp_pkg.sv
// Shared types and constants for the video link command parser.
// No dependencies; used by every other file of the block.
package vlcp_pkg;

  localparam int ADDR_W  = 11;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int FRAME_BYTES_DEF = 1024;

  // command nibbles seen in idle
  localparam logic [3:0] CMD_MEM   = 4'h1;
  localparam logic [3:0] CMD_FRAME = 4'h2;
  localparam logic [3:0] CMD_CTRL  = 4'h3;
  localparam logic [3:0] CMD_DIP   = 4'h4;

  // write kinds
  localparam logic [KIND_W-1:0] KIND_MEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CTRL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIP  = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_ADDRLO = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_CTRL   = 6'b001000,
    PH_DIP    = 6'b010000,
    PH_FRAME  = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] remain;
  } parse_state_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
  } wr_result_t;

endpackage

// File: hdl/video_link_command_parser_core.sv
// Video link command parser: one byte per cycle in while the output is not stalled, at most one write out per byte.
// Top level; depends on vlcp_pkg and vlcp_decode.
//
// Takes one link byte per cycle and turns the command stream into screen
// memory, control register and DIP switch writes. Throughput is one item
// per clock while the output is not stalled. An accepted byte lands in the
// input register, the decoder updates the parse state from it, and its
// write (if any) is loaded into the output register when the decoder
// advances, which raises out_valid. The decoder advances whenever the
// output register is empty or being drained, or when the byte produces no
// write; out_ready low only stalls bytes that actually carry a write.
// No memory, no clearing pass.
module video_link_command_parser_core #(
  parameter int FRAME_BYTES = vlcp_pkg::FRAME_BYTES_DEF  // 1 .. 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vlcp_pkg::BYTE_W-1:0]   in_link_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vlcp_pkg::KIND_W-1:0]   out_write_kind,
  output logic [vlcp_pkg::ADDR_W-1:0]   out_write_address,
  output logic [vlcp_pkg::BYTE_W-1:0]   out_write_value
);

  // input register
  logic                        in_vld_r;
  logic [vlcp_pkg::BYTE_W-1:0] in_byte_r;

  // parse state
  vlcp_pkg::parse_state_t st_r, st_nxt;
  vlcp_pkg::wr_result_t   res;

  // output register
  logic                        out_vld_r;
  logic [vlcp_pkg::KIND_W-1:0] out_kind_r;
  logic [vlcp_pkg::ADDR_W-1:0] out_addr_r;
  logic [vlcp_pkg::BYTE_W-1:0] out_val_r;

  logic advance;

  vlcp_decode #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_decode (
    .st      (st_r),
    .byte_in (in_byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // byte in the input register moves on unless its write would hit a full,
  // stalled output register
  assign advance  = in_vld_r && (!res.valid || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r         <= 1'b0;
      st_r.phase       <= vlcp_pkg::PH_IDLE;
      st_r.addr        <= '0;
      st_r.remain      <= '0;
      out_vld_r        <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && res.valid) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_link_byte;
    end
    if (advance && res.valid) begin
      out_kind_r <= res.kind;
      out_addr_r <= res.addr;
      out_val_r  <= res.value;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_write_kind    = out_kind_r;
  assign out_write_address = out_addr_r;
  assign out_write_value   = out_val_r;

endmodule

// File: hdl/vlcp_decode.sv
// Byte decoder: next parse state and optional write for one link byte.
// Depends on vlcp_pkg.
module vlcp_decode #(
  parameter int FRAME_BYTES = vlcp_pkg::FRAME_BYTES_DEF
) (
  input  vlcp_pkg::parse_state_t     st,
  input  logic [vlcp_pkg::BYTE_W-1:0] byte_in,
  output vlcp_pkg::parse_state_t     st_nxt,
  output vlcp_pkg::wr_result_t       res
);

  localparam int AW = vlcp_pkg::ADDR_W;
  localparam logic [AW-1:0] FRAME_LAST = AW'(FRAME_BYTES - 1);

  always_comb begin
    st_nxt    = st;
    res.valid = 1'b0;
    res.kind  = vlcp_pkg::KIND_MEM;
    res.addr  = '0;
    res.value = byte_in;
    unique case (st.phase)
      vlcp_pkg::PH_ADDRLO: begin
        st_nxt.addr  = st.addr + {{(AW-vlcp_pkg::BYTE_W){1'b0}}, byte_in};
        st_nxt.phase = vlcp_pkg::PH_DATA;
      end
      vlcp_pkg::PH_DATA: begin
        res.valid    = 1'b1;
        res.addr     = st.addr;
        st_nxt.phase = vlcp_pkg::PH_IDLE;
      end
      vlcp_pkg::PH_CTRL: begin
        res.valid    = 1'b1;
        res.kind     = vlcp_pkg::KIND_CTRL;
        st_nxt.phase = vlcp_pkg::PH_IDLE;
      end
      vlcp_pkg::PH_DIP: begin
        res.valid    = 1'b1;
        res.kind     = vlcp_pkg::KIND_DIP;
        st_nxt.phase = vlcp_pkg::PH_IDLE;
      end
      vlcp_pkg::PH_FRAME: begin
        res.valid   = 1'b1;
        res.addr    = st.addr;
        st_nxt.addr = st.addr + AW'(1);
        if (st.remain == '0) begin
          st_nxt.phase = vlcp_pkg::PH_IDLE;
        end else begin
          st_nxt.remain = st.remain - AW'(1);
        end
      end
      default: begin
        // idle, and any illegal code behaves as idle
        st_nxt.phase = vlcp_pkg::PH_IDLE;
        case (byte_in[7:4])
          vlcp_pkg::CMD_MEM: begin
            st_nxt.addr  = {byte_in[2:0], 8'h00};
            st_nxt.phase = vlcp_pkg::PH_ADDRLO;
          end
          vlcp_pkg::CMD_FRAME: begin
            st_nxt.addr   = '0;
            st_nxt.remain = FRAME_LAST;
            st_nxt.phase  = vlcp_pkg::PH_FRAME;
          end
          vlcp_pkg::CMD_CTRL: st_nxt.phase = vlcp_pkg::PH_CTRL;
          vlcp_pkg::CMD_DIP:  st_nxt.phase = vlcp_pkg::PH_DIP;
          default: ;
        endcase
      end
    endcase
  end

endmodule

// File: hdl/vlcp_checker.sv
// Port-level checker for the video link command parser, bound to the top level.
// Depends on vlcp_pkg and video_link_command_parser_core.
module vlcp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [vlcp_pkg::KIND_W-1:0]   out_write_kind,
  input logic [vlcp_pkg::ADDR_W-1:0]   out_write_address,
  input logic [vlcp_pkg::BYTE_W-1:0]   out_write_value
);

  // no write may come out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a held write keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_kind)
      && $stable(out_write_address) && $stable(out_write_value))
    else $error("stalled write changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_kind == vlcp_pkg::KIND_MEM ||
                   out_write_kind == vlcp_pkg::KIND_CTRL ||
                   out_write_kind == vlcp_pkg::KIND_DIP))
    else $error("illegal write kind");

  a_reg_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_kind != vlcp_pkg::KIND_MEM |-> out_write_address == '0)
    else $error("register write with nonzero address");

  // after reset, a write cannot appear before a byte has been accepted
  a_no_early_out: assert property (@(posedge clk)
    !rst_n ##1 !(in_valid && in_ready) |=> !out_valid)
    else $error("write without a preceding byte");

endmodule

bind video_link_command_parser_core vlcp_checker u_vlcp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_write_kind    (out_write_kind),
  .out_write_address (out_write_address),
  .out_write_value   (out_write_value)
);
